// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl, compiled out under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error(msg);

`else

`define ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/core/ycrp_pkg.sv =====
// types and constants of the ycbcr 4:2:0 to packed rgb converter
`timescale 1ns / 1ps

package ycrp_pkg;

    localparam int SUM_W = 27;

    // bt.601 studio range coefficients in signed q2.16 (19 bits, 16 fraction bits)
    localparam logic signed [18:0] Y_COEF      = 19'sd76284;
    localparam logic signed [18:0] CR_RED_COEF = 19'sd104595;
    localparam logic signed [18:0] CR_GRN_COEF = -19'sd53280;
    localparam logic signed [18:0] CB_GRN_COEF = -19'sd25624;
    localparam logic signed [18:0] CB_BLU_COEF = 19'sd132252;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 27'sd32768;

    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

    localparam logic [1:0] LAST_IDX_FULL = 2'd3;
    localparam logic [1:0] LAST_IDX_HALF = 2'd1;

    typedef enum logic [1:0] {
        FMT_RGB555 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_BGR24  = 2'd2,
        FMT_BGR32  = 2'd3
    } ycrp_fmt_t;

    localparam ycrp_fmt_t FMT_RESET = FMT_BGR32;

    typedef struct packed {
        logic lower_row;
        logic last_of_group;
    } ycrp_side_t;

    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        ycrp_side_t side;
    } ycrp_pix_t;

    typedef struct packed {
        logic       busy;
        logic       last;
        logic [1:0] idx;
    } ycrp_split_stat_t;

endpackage

// ===== rtl/core/ycrp_split.sv =====
// holds one 4:2:0 group and feeds its pixels into the pipeline one per cycle while advance is high
`timescale 1ns / 1ps

module ycrp_split
    import ycrp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_luma_top_left,
    input  logic [7:0]       s_luma_top_right,
    input  logic [7:0]       s_luma_bottom_left,
    input  logic [7:0]       s_luma_bottom_right,
    input  logic [7:0]       s_chroma_blue,
    input  logic [7:0]       s_chroma_red,
    input  logic             s_single_row,
    input  logic             advance,
    output logic             pix_valid,
    output ycrp_pix_t        pix,
    output ycrp_split_stat_t stat
);

    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic [7:0] luma_reg [4];
    logic [7:0] cb_reg;
    logic [7:0] cr_reg;
    logic       single_reg;
    logic       last;
    logic       take;

    assign last    = single_reg ? (idx_reg == LAST_IDX_HALF) : (idx_reg == LAST_IDX_FULL);
    assign s_ready = !busy_reg || (advance && last);
    assign take    = s_valid && s_ready;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (busy_reg && advance) begin
            if (last) begin
                busy_next = 1'b0;
            end
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            luma_reg[0] <= s_luma_top_left;
            luma_reg[1] <= s_luma_top_right;
            luma_reg[2] <= s_luma_bottom_left;
            luma_reg[3] <= s_luma_bottom_right;
            cb_reg      <= s_chroma_blue;
            cr_reg      <= s_chroma_red;
            single_reg  <= s_single_row;
        end
    end

    assign pix_valid               = busy_reg;
    assign pix.luma                = luma_reg[idx_reg];
    assign pix.cb                  = cb_reg;
    assign pix.cr                  = cr_reg;
    assign pix.side.lower_row      = idx_reg[1];
    assign pix.side.last_of_group  = last;

    assign stat.busy = busy_reg;
    assign stat.last = last;
    assign stat.idx  = idx_reg;

endmodule

// ===== rtl/core/ycrp_conv.sv =====
// two pipeline stages: coefficient products, then per-channel rounded sums
`timescale 1ns / 1ps

module ycrp_conv
    import ycrp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic                    in_valid,
    input  ycrp_pix_t               pix,
    output logic                    out_valid,
    output ycrp_side_t              out_side,
    output logic signed [SUM_W-1:0] r_sum,
    output logic signed [SUM_W-1:0] g_sum,
    output logic signed [SUM_W-1:0] b_sum
);

    logic signed [8:0] y_diff;
    logic signed [8:0] cb_diff;
    logic signed [8:0] cr_diff;

    logic                    v1_reg;
    ycrp_side_t              side1_reg;
    logic signed [SUM_W-1:0] y_prod_reg;
    logic signed [SUM_W-1:0] cr_red_reg;
    logic signed [SUM_W-1:0] cr_grn_reg;
    logic signed [SUM_W-1:0] cb_grn_reg;
    logic signed [SUM_W-1:0] cb_blu_reg;

    logic                    v2_reg;
    ycrp_side_t              side2_reg;
    logic signed [SUM_W-1:0] r_sum_reg;
    logic signed [SUM_W-1:0] g_sum_reg;
    logic signed [SUM_W-1:0] b_sum_reg;

    assign y_diff  = $signed({1'b0, pix.luma}) - LUMA_OFFSET;
    assign cb_diff = $signed({1'b0, pix.cb}) - CHROMA_OFFSET;
    assign cr_diff = $signed({1'b0, pix.cr}) - CHROMA_OFFSET;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            side1_reg  <= pix.side;
            y_prod_reg <= SUM_W'(y_diff * Y_COEF);
            cr_red_reg <= SUM_W'(cr_diff * CR_RED_COEF);
            cr_grn_reg <= SUM_W'(cr_diff * CR_GRN_COEF);
            cb_grn_reg <= SUM_W'(cb_diff * CB_GRN_COEF);
            cb_blu_reg <= SUM_W'(cb_diff * CB_BLU_COEF);

            side2_reg  <= side1_reg;
            r_sum_reg  <= y_prod_reg + cr_red_reg + ROUND_HALF;
            g_sum_reg  <= y_prod_reg + cr_grn_reg + cb_grn_reg + ROUND_HALF;
            b_sum_reg  <= y_prod_reg + cb_blu_reg + ROUND_HALF;
        end
    end

    assign out_valid = v2_reg;
    assign out_side  = side2_reg;
    assign r_sum     = r_sum_reg;
    assign g_sum     = g_sum_reg;
    assign b_sum     = b_sum_reg;

endmodule

// ===== rtl/core/ycrp_pack.sv =====
// last stage: clamp each channel to a byte and pack into the output register
`timescale 1ns / 1ps

module ycrp_pack
    import ycrp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  ycrp_fmt_t               fmt,
    input  logic                    in_valid,
    input  ycrp_side_t              in_side,
    input  logic signed [SUM_W-1:0] r_sum,
    input  logic signed [SUM_W-1:0] g_sum,
    input  logic signed [SUM_W-1:0] b_sum,
    output logic                    m_valid,
    output logic [23:0]             m_pixel_word,
    output logic                    m_lower_row,
    output logic                    m_last_of_group
);

    function automatic logic [7:0] clip8(input logic signed [SUM_W-1:0] s);
        logic [7:0] v;
        if (s[SUM_W-1]) begin
            v = 8'd0;
        end else if (|s[SUM_W-2:24]) begin
            v = 8'hff;
        end else begin
            v = s[23:16];
        end
        return v;
    endfunction

    logic [7:0]  r8, g8, b8;
    logic [23:0] word;

    logic        valid_reg;
    logic [23:0] word_reg;
    ycrp_side_t  side_reg;

    assign r8 = clip8(r_sum);
    assign g8 = clip8(g_sum);
    assign b8 = clip8(b_sum);

    always_comb begin
        unique case (fmt)
            FMT_RGB555: word = {9'd0, r8[7:3], g8[7:3], b8[7:3]};
            FMT_RGB565: word = {8'd0, r8[7:3], g8[7:2], b8[7:3]};
            FMT_BGR24:  word = {r8, g8, b8};
            FMT_BGR32:  word = {r8, g8, b8};
            default:    word = {r8, g8, b8};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            word_reg <= word;
            side_reg <= in_side;
        end
    end

    assign m_valid         = valid_reg;
    assign m_pixel_word    = word_reg;
    assign m_lower_row     = side_reg.lower_row;
    assign m_last_of_group = side_reg.last_of_group;

endmodule

// ===== rtl/core/ycbcr420_to_rgb_pack_top.sv =====
// ycbcr 4:2:0 group to packed rgb pixel stream, top level
//
// input channel (s_*): one 2x2 group per item, four luma samples, the shared
// cb/cr pair and a single-row flag for the last line of an odd-height frame.
// result channel (m_*): one packed pixel per item in row order, top-left,
// top-right, bottom-left, bottom-right; lower_row marks the bottom pair and
// last_of_group the final pixel of the group. a single-row group gives only
// the top pair.
// throughput: one pixel per cycle while the receiver does not stall; the group
// holding register is reloaded in the cycle its last pixel leaves, so groups
// follow each other with no gap.
// path from group accept to its first pixel on m_*: the accept edge loads the
// group register, then the pixel passes through the product stage, the sum
// stage and the clamp/pack output register in turn.
// cfg_wr_en/cfg_wr_data write the output format, reset value 32-bit bgr.
// reset clears the valid bits of every stage; no group is held.
// when the receiver stalls the whole pipeline holds, nothing is lost, and
// s_ready drops once the group register is busy.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ycbcr420_to_rgb_pack_top
    import ycrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_luma_top_left,
    input  logic [7:0]  s_luma_top_right,
    input  logic [7:0]  s_luma_bottom_left,
    input  logic [7:0]  s_luma_bottom_right,
    input  logic [7:0]  s_chroma_blue,
    input  logic [7:0]  s_chroma_red,
    input  logic        s_single_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_pixel_word,
    output logic        m_lower_row,
    output logic        m_last_of_group
);

    ycrp_fmt_t fmt_reg;

    logic                    advance;
    logic                    pix_valid;
    ycrp_pix_t               pix;
    ycrp_split_stat_t        split_stat;
    logic                    sum_valid;
    ycrp_side_t              sum_side;
    logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_wr_en) begin
            fmt_reg <= ycrp_fmt_t'(cfg_wr_data);
        end
    end

    // whole pipeline moves together unless the output register is stuck
    assign advance = !m_valid || m_ready;

    ycrp_split u_split (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_luma_top_left     (s_luma_top_left),
        .s_luma_top_right    (s_luma_top_right),
        .s_luma_bottom_left  (s_luma_bottom_left),
        .s_luma_bottom_right (s_luma_bottom_right),
        .s_chroma_blue       (s_chroma_blue),
        .s_chroma_red        (s_chroma_red),
        .s_single_row        (s_single_row),
        .advance             (advance),
        .pix_valid           (pix_valid),
        .pix                 (pix),
        .stat                (split_stat)
    );

    ycrp_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (pix_valid),
        .pix       (pix),
        .out_valid (sum_valid),
        .out_side  (sum_side),
        .r_sum     (r_sum),
        .g_sum     (g_sum),
        .b_sum     (b_sum)
    );

    ycrp_pack u_pack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .fmt             (fmt_reg),
        .in_valid        (sum_valid),
        .in_side         (sum_side),
        .r_sum           (r_sum),
        .g_sum           (g_sum),
        .b_sum           (b_sum),
        .m_valid         (m_valid),
        .m_pixel_word    (m_pixel_word),
        .m_lower_row     (m_lower_row),
        .m_last_of_group (m_last_of_group)
    );

    `ASSERT_NEXT(a_accept_loads, aclk, aresetn, s_valid && s_ready, split_stat.busy && (split_stat.idx == 2'd0), "accepted item did not load the group register")
    `ASSERT_NEXT(a_stall_holds_idx, aclk, aresetn, split_stat.busy && !advance, $stable(split_stat.idx) && split_stat.busy, "pixel index moved during a stall")
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, s_valid && s_ready && split_stat.busy && !(advance && split_stat.last), "item accepted while group still emitting")

endmodule
